// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and disabled during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// overlapping implication (|->); ASSERT_NEXT below gives the |=> form
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ddpt_pkg.sv =====
// ---------------------------------------------------------------------------
// ddpt_pkg
// shared widths, controller states and command/status types
// ---------------------------------------------------------------------------
package ddpt_pkg;

    localparam int EQUITY_BITS   = 48;
    localparam int FRACTION_BITS = 16;
    localparam int INDEX_BITS    = 24;

    localparam int STEP_CNT_BITS  = $clog2(FRACTION_BITS);
    localparam int IN_TDATA_BITS  = ((EQUITY_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * FRACTION_BITS + INDEX_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture sample, update peak, set up divider
        logic step;    // one restoring division step
        logic commit;  // update statistics and load output register
    } ddpt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bypass;  // drawdown known without division
    } ddpt_status_t;

endpackage

// ===== rtl/ddpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ddpt_ctrl
// sequencer: accept, divide one quotient bit per cycle unless bypassed, write back result
// ---------------------------------------------------------------------------
module ddpt_ctrl
    import ddpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  ddpt_status_t status,
    output ddpt_cmd_t    cmd
);

    state_t                   state_reg, state_next;
    logic [STEP_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_tready     = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.bypass) begin
                    state_next = ST_WB;
                end else begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == STEP_CNT_BITS'(FRACTION_BITS - 1)) begin
                        state_next = ST_WB;
                    end
                end
            end
            ST_WB: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== rtl/ddpt_datapath.sv =====
// ---------------------------------------------------------------------------
// ddpt_datapath
// peak tracking, restoring divider, period statistics and result register
// ---------------------------------------------------------------------------
module ddpt_datapath
    import ddpt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ddpt_cmd_t                cmd,
    output ddpt_status_t             status,
    input  logic [EQUITY_BITS-1:0]   equity_value,
    input  logic                     series_last,
    output logic [FRACTION_BITS-1:0] drawdown,
    output logic                     period_closed,
    output logic [INDEX_BITS-1:0]    period_length,
    output logic [FRACTION_BITS-1:0] period_peak,
    output logic [FRACTION_BITS-1:0] max_drawdown,
    output logic                     series_end
);

    // series state
    logic [EQUITY_BITS-1:0]   peak_reg;
    logic [INDEX_BITS-1:0]    index_reg;
    logic [INDEX_BITS-1:0]    start_reg;
    logic [FRACTION_BITS-1:0] period_deep_reg;
    logic [FRACTION_BITS-1:0] series_deep_reg;

    // per-sample working registers
    logic                     at_peak_reg;
    logic                     full_loss_reg;
    logic                     last_reg;
    logic [EQUITY_BITS-1:0]   rem_reg;
    logic [FRACTION_BITS-1:0] quot_reg;

    // result register
    logic [FRACTION_BITS-1:0] dd_out_reg;
    logic                     closed_out_reg;
    logic [INDEX_BITS-1:0]    len_out_reg;
    logic [FRACTION_BITS-1:0] ppeak_out_reg;
    logic [FRACTION_BITS-1:0] max_out_reg;
    logic                     end_out_reg;

    logic [EQUITY_BITS:0]     rem_shift;
    logic [EQUITY_BITS:0]     rem_diff;
    logic                     rem_ge;
    logic                     load_at_peak;
    logic [FRACTION_BITS-1:0] dd_val;
    logic [FRACTION_BITS-1:0] series_new;
    logic [FRACTION_BITS-1:0] period_new;
    logic [INDEX_BITS-1:0]    span;
    logic                     boundary;
    logic                     closed;

    assign load_at_peak = (equity_value >= peak_reg);

    // restoring step: remainder stays below the peak
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, peak_reg};
    assign rem_ge    = (rem_shift >= {1'b0, peak_reg});

    assign dd_val     = at_peak_reg   ? '0 :
                        full_loss_reg ? '1 : quot_reg;
    assign series_new = (dd_val > series_deep_reg) ? dd_val : series_deep_reg;
    assign period_new = (dd_val > period_deep_reg) ? dd_val : period_deep_reg;
    assign span       = index_reg - start_reg;
    assign boundary   = at_peak_reg || last_reg;
    assign closed     = boundary && (span > INDEX_BITS'(1));

    assign status.bypass = at_peak_reg || full_loss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg        <= '0;
            index_reg       <= '0;
            start_reg       <= '0;
            period_deep_reg <= '0;
            series_deep_reg <= '0;
        end else if (cmd.load) begin
            if (load_at_peak) begin
                peak_reg <= equity_value;
            end
        end else if (cmd.commit) begin
            if (last_reg) begin
                peak_reg        <= '0;
                index_reg       <= '0;
                start_reg       <= '0;
                period_deep_reg <= '0;
                series_deep_reg <= '0;
            end else begin
                index_reg       <= index_reg + 1'b1;
                series_deep_reg <= series_new;
                if (boundary) begin
                    start_reg       <= index_reg;
                    period_deep_reg <= '0;
                end else begin
                    period_deep_reg <= period_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            at_peak_reg   <= load_at_peak;
            full_loss_reg <= (equity_value == '0) && (peak_reg != '0);
            last_reg      <= series_last;
            rem_reg       <= peak_reg - equity_value;
            quot_reg      <= '0;
        end else if (cmd.step) begin
            quot_reg <= {quot_reg[FRACTION_BITS-2:0], rem_ge};
            if (rem_ge) begin
                rem_reg <= rem_diff[EQUITY_BITS-1:0];
            end else begin
                rem_reg <= rem_shift[EQUITY_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            dd_out_reg     <= dd_val;
            closed_out_reg <= closed;
            len_out_reg    <= closed ? span : '0;
            ppeak_out_reg  <= closed ? period_new : '0;
            max_out_reg    <= series_new;
            end_out_reg    <= last_reg;
        end
    end

    assign drawdown      = dd_out_reg;
    assign period_closed = closed_out_reg;
    assign period_length = len_out_reg;
    assign period_peak   = ppeak_out_reg;
    assign max_drawdown  = max_out_reg;
    assign series_end    = end_out_reg;

endmodule

// ===== rtl/drawdown_period_tracker.sv =====
// ---------------------------------------------------------------------------
// drawdown_period_tracker
// streaming maximum-drawdown and drawdown-period tracker
// ---------------------------------------------------------------------------
// One unsigned equity sample goes in per transfer, with tlast marking the
// last sample of a series; exactly one result transfer comes out per sample.
// The block keeps the running peak and reports the drawdown (peak-equity)/peak
// as a floored Q0.16 fraction (a total loss reads 0xffff, a zero peak reads 0).
// A sample equal to the peak, or the last sample, closes the open period; a
// period longer than one sample is reported with its length and deepest
// drawdown. All state clears after the last sample. A sample below the peak is
// accepted, passed through the restoring divider, which produces one quotient
// bit per cycle, and written back; a sample at or above the peak, or a zero
// sample below a nonzero peak, skips the divider. The result sits in an output
// register, so the next sample is taken and divided while the previous result
// waits for m_tready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module drawdown_period_tracker
    import ddpt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // input channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // equity_value
    input  logic                      s_tlast,   // series_last
    // result channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // drawdown, period_length,
                                                 // period_peak, max_drawdown
    output logic                      m_tuser,   // period_closed
    output logic                      m_tlast    // series_end
);

    ddpt_cmd_t                cmd;
    ddpt_status_t             status;
    logic [FRACTION_BITS-1:0] drawdown;
    logic                     period_closed;
    logic [INDEX_BITS-1:0]    period_length;
    logic [FRACTION_BITS-1:0] period_peak;
    logic [FRACTION_BITS-1:0] max_drawdown;
    logic                     series_end;

    // sequencer: handshakes and divider step count
    ddpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // peak, divider, period statistics and result register
    ddpt_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .equity_value  (s_tdata[EQUITY_BITS-1:0]),
        .series_last   (s_tlast),
        .drawdown      (drawdown),
        .period_closed (period_closed),
        .period_length (period_length),
        .period_peak   (period_peak),
        .max_drawdown  (max_drawdown),
        .series_end    (series_end)
    );

    // pack result fields lowest first, zero padded to whole bytes
    assign m_tdata = OUT_TDATA_BITS'({max_drawdown, period_peak, period_length, drawdown});
    assign m_tuser = period_closed;
    assign m_tlast = series_end;

    // a sample is never taken in the cycle a result is written back
    `ASSERT_ALWAYS(a_load_commit_excl, aclk, aresetn, !(cmd.load && cmd.commit))
    // write back only into a free or draining output register
    `ASSERT_IMPLIES(a_commit_slot_free, aclk, aresetn, cmd.commit, !m_tvalid || m_tready)
    // a written result is offered in the next cycle
    `ASSERT_NEXT(a_commit_shows, aclk, aresetn, cmd.commit, m_tvalid)
    // after a sample is taken the input side is busy
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for drawdown_period_tracker
// ---------------------------------------------------------------------------
// Equity samples are queued up front: a short directed set, then random series
// of mostly well-formed price paths with some noise. A clocked driver sends
// them in random bursts, and a clocked monitor takes results behind a
// changing stall pattern. Each accepted sample runs through a local drawdown
// tracker. Its expected result is compared field by field with the next
// result transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ddpt_pkg::*;

    typedef struct packed {
        logic [EQUITY_BITS-1:0] equity;
        logic                   last;
        logic                   hold;   // wait for all results before sending
    } sample_t;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] drawdown;
        logic                     closed;
        logic [INDEX_BITS-1:0]    length;
        logic [FRACTION_BITS-1:0] worst;
        logic [FRACTION_BITS-1:0] max_dd;
        logic                     series_end;
    } dd_result_t;

    localparam logic [EQUITY_BITS-1:0] EQ_MAX = '1;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;   // equity_value
    logic                      s_tlast  = 1'b0; // series_last
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;         // drawdown, period_length,
                                                // period_peak, max_drawdown
    logic                      m_tuser;         // period_closed
    logic                      m_tlast;         // series_end

    drawdown_period_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // drawdown tracker state
    // -----------------------------------------------------------------------
    logic [EQUITY_BITS-1:0]   peak_equity  = '0;
    logic [INDEX_BITS-1:0]    next_idx     = '0;
    logic [INDEX_BITS-1:0]    period_start = '0;
    logic [FRACTION_BITS-1:0] period_worst = '0;
    logic [FRACTION_BITS-1:0] series_worst = '0;

    sample_t    samples_q[$];
    dd_result_t expected_q[$];
    sample_t    cur_sample;

    int samples_taken    = 0;
    int results_seen     = 0;
    int periods_reported = 0;
    int series_done      = 0;
    int full_losses      = 0;
    int mismatches       = 0;

    // floored (peak - value) / peak in Q0.FRACTION_BITS, total loss saturates
    function automatic logic [FRACTION_BITS-1:0] loss_fraction(
        logic [EQUITY_BITS-1:0] value, logic [EQUITY_BITS-1:0] peak);
        logic [EQUITY_BITS+FRACTION_BITS-1:0] num;
        if (peak == '0 || value >= peak) return '0;
        if (value == '0) return '1;
        num = {(peak - value), {FRACTION_BITS{1'b0}}};
        return FRACTION_BITS'(num / peak);
    endfunction

    function automatic dd_result_t track_sample(sample_t s);
        dd_result_t               r;
        logic [INDEX_BITS-1:0]    idx;
        logic [INDEX_BITS-1:0]    span;
        logic [FRACTION_BITS-1:0] dd;
        logic                     at_peak;
        idx = next_idx;
        if (s.equity >= peak_equity) peak_equity = s.equity;
        at_peak = (s.equity == peak_equity);
        dd = at_peak ? '0 : loss_fraction(s.equity, peak_equity);
        if (dd > series_worst) series_worst = dd;
        if (dd > period_worst) period_worst = dd;
        r = '0;
        r.drawdown = dd;
        // a sample at the peak or the end of the series closes the open period
        if (at_peak || s.last) begin
            span = idx - period_start;
            if (span > 1) begin
                r.closed = 1'b1;
                r.length = span;
                r.worst  = period_worst;
            end
            period_start = idx;
            period_worst = '0;
        end
        r.max_dd     = series_worst;
        r.series_end = s.last;
        next_idx     = idx + 1'b1;
        if (s.last) begin
            peak_equity  = '0;
            next_idx     = '0;
            period_start = '0;
            period_worst = '0;
            series_worst = '0;
        end
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    function automatic logic [EQUITY_BITS-1:0] rand_bits(int w);
        logic [63:0]            raw;
        logic [EQUITY_BITS-1:0] m;
        raw = {$urandom, $urandom};
        m = (w >= EQUITY_BITS) ? '1 : ((EQUITY_BITS'(1) << w) - 1'b1);
        return raw[EQUITY_BITS-1:0] & m;
    endfunction

    task automatic add_sample(logic [EQUITY_BITS-1:0] v, logic last, logic hold);
        sample_t s;
        s.equity = v;
        s.last   = last;
        s.hold   = hold;
        samples_q = {samples_q, s};
    endtask

    // a price path at a random scale: new highs, returns to the peak, dips,
    // total losses; one series in ten is plain noise
    task automatic queue_random_series();
        int                     len;
        int                     scale;
        int                     pick;
        bit                     noisy;
        logic [EQUITY_BITS-1:0] top;
        logic [EQUITY_BITS-1:0] v;
        logic [EQUITY_BITS-1:0] d;
        len   = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 40);
        scale = $urandom_range(1, EQUITY_BITS);
        noisy = ($urandom_range(0, 9) == 0);
        top   = '0;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (noisy) begin
                v = rand_bits($urandom_range(1, EQUITY_BITS));
            end else if (top == '0 || pick < 10) begin
                v = top + rand_bits($urandom_range(0, scale));
            end else if (pick < 25) begin
                v = top;
            end else if (pick < 30) begin
                v = '0;
            end else if (pick < 32) begin
                v = EQ_MAX;
            end else begin
                d = rand_bits($urandom_range(0, scale));
                v = (d <= top) ? top - d : d % (top + 1'b1);
            end
            if (v > top) top = v;
            add_sample(v, i == len - 1, $urandom_range(0, 99) == 0);
        end
    endtask

    initial begin
        // single-sample series at a zero peak
        add_sample('0, 1'b1, 1'b0);
        // zero peak, short periods, full loss, a reported period, extremes,
        // and a last sample that lands on the peak
        add_sample('0, 1'b0, 1'b0);
        add_sample('0, 1'b0, 1'b0);
        add_sample(48'd1000, 1'b0, 1'b0);
        add_sample(48'd999, 1'b0, 1'b0);
        add_sample(48'd500, 1'b0, 1'b0);
        add_sample('0, 1'b0, 1'b0);
        add_sample(48'd1000, 1'b0, 1'b0);
        add_sample(48'd1000, 1'b0, 1'b0);
        add_sample(EQ_MAX, 1'b0, 1'b0);
        add_sample(48'd1, 1'b0, 1'b0);
        add_sample(EQ_MAX - 1'b1, 1'b0, 1'b0);
        add_sample(EQ_MAX, 1'b0, 1'b0);
        add_sample(48'd5, 1'b0, 1'b0);
        add_sample(EQ_MAX, 1'b1, 1'b0);
        // series ending below its peak, sent only once the block has drained
        add_sample(48'd7, 1'b0, 1'b1);
        add_sample(48'd7, 1'b0, 1'b0);
        add_sample(48'd6, 1'b0, 1'b0);
        add_sample(48'd3, 1'b0, 1'b0);
        add_sample(48'd1, 1'b1, 1'b0);
        // alternating bit patterns
        add_sample(48'haaaa_aaaa_aaaa, 1'b0, 1'b0);
        add_sample(48'h5555_5555_5555, 1'b1, 1'b0);
        while (samples_q.size() < 1550) queue_random_series();

        while (samples_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("covered %0d samples over %0d series: %0d periods closed, %0d total losses",
                 samples_taken, series_done, periods_reported, full_losses);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("TB_ERROR");
        $finish;
    end

    // -----------------------------------------------------------------------
    // driver: bursts of transfers with random gaps between them
    // -----------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q = {expected_q, track_sample(cur_sample)};
                samples_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    s_tvalid <= 1'b0;
                    gap_left--;
                end else if (samples_q.size() != 0 &&
                             !(samples_q[0].hold && expected_q.size() != 0)) begin
                    cur_sample = samples_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_sample.equity;
                    s_tlast  <= cur_sample.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // monitor: result checks, with a receiver that changes its stall pattern
    // -----------------------------------------------------------------------
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    task automatic compare_field(string fname, longint unsigned want,
                                 longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, fname, want, got);
        end
    endtask

    always @(posedge aclk) begin
        dd_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected, expected none got 0x%0h",
                             $time, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("drawdown", want.drawdown, m_tdata[FRACTION_BITS-1:0]);
                    compare_field("period_closed", want.closed, m_tuser);
                    compare_field("period_length", want.length,
                                  m_tdata[FRACTION_BITS +: INDEX_BITS]);
                    compare_field("period_peak", want.worst,
                                  m_tdata[FRACTION_BITS+INDEX_BITS +: FRACTION_BITS]);
                    compare_field("max_drawdown", want.max_dd,
                                  m_tdata[2*FRACTION_BITS+INDEX_BITS +: FRACTION_BITS]);
                    compare_field("series_end", want.series_end, m_tlast);
                    if (want.closed) periods_reported++;
                    if (want.series_end) series_done++;
                    if (want.drawdown == '1) full_losses++;
                end
            end
            // modes: always ready, coin flip, mostly stalled, fixed duty cycle
            if (rx_left <= 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= ((rx_tick % 7) >= 3);
                end
            endcase
        end
    end

endmodule
